/* design/aes_pkg.sv */
// aes_pkg: shared types, constants and round functions for the aes block encrypt unit
// no dependencies; used by aes_key_expand, aes_block_encrypt_unit and the testbench
`default_nettype none
package aes_pkg;

  localparam int unsigned KEY_IDX_W  = 5;
  localparam int unsigned WORD_CNT_W = 6;
  localparam int unsigned NUM_STAGES = 14;

  localparam logic [1:0] KS_128 = 2'd0;
  localparam logic [1:0] KS_192 = 2'd1;

  localparam logic [3:0] ROUNDS_128 = 4'd10;
  localparam logic [3:0] ROUNDS_192 = 4'd12;
  localparam logic [3:0] ROUNDS_256 = 4'd14;

  localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
  localparam logic [2:0] CFG_KEY_W0   = 3'd1;
  localparam logic [2:0] CFG_KEY_W3   = 3'd4;

  typedef enum logic {
    KX_IDLE,
    KX_RUN
  } kx_state_t;

  typedef struct packed {
    logic                 en;
    logic [KEY_IDX_W-1:0] idx;
    logic [63:0]          data;
  } rk_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] b);
    return SBOX[b];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // byte r + 4c of the state is row r, column c; byte 0 sits in bits 7:0
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0]   t [16];
    logic [127:0] o;
    logic [7:0]   a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = sbox(s[8*(r + 4*((c + r) & 3)) +: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0  = t[4*c];
      a1  = t[4*c + 1];
      a2  = t[4*c + 2];
      a3  = t[4*c + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        o[32*c +: 32] = {a3, a2, a1, a0};
      end else begin
        o[32*c +: 32] = {a3 ^ all ^ xtime(a3 ^ a0), a2 ^ all ^ xtime(a2 ^ a3),
                         a1 ^ all ^ xtime(a1 ^ a2), a0 ^ all ^ xtime(a0 ^ a1)};
      end
    end
    return o ^ k;
  endfunction

  function automatic logic [3:0] round_count(input logic [1:0] ks);
    logic [3:0] nr;
    case (ks)
      KS_128:  nr = ROUNDS_128;
      KS_192:  nr = ROUNDS_192;
      default: nr = ROUNDS_256;
    endcase
    return nr;
  endfunction

endpackage
`default_nettype wire

/* design/aes_if.sv */
// aes_in_if and aes_out_if: valid/ready request channels for plaintext and ciphertext
// no dependencies
`default_nettype none
interface aes_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_low;
  logic [63:0] plain_high;
  modport source (output valid, output plain_low, output plain_high, input ready);
  modport sink   (input valid, input plain_low, input plain_high, output ready);
endinterface

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_low;
  logic [63:0] cipher_high;
  modport source (output valid, output cipher_low, output cipher_high, input ready);
  modport sink   (input valid, input cipher_low, input cipher_high, output ready);
endinterface
`default_nettype wire

/* design/aes_key_expand.sv */
// aes_key_expand: one 32-bit key schedule word per cycle, writes 64-bit round key entries
// depends on aes_pkg
`default_nettype none
module aes_key_expand (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [1:0]        key_size,
  input  wire logic [3:0][63:0]  key_word,
  output aes_pkg::rk_wr_t        wr,
  output logic                   busy
);

  aes_pkg::kx_state_t state_r, state_nxt;

  logic [aes_pkg::WORD_CNT_W-1:0] i_r, i_nxt;
  logic [2:0]                     m_r, m_nxt;
  logic [7:0]                     rcon_r, rcon_nxt;
  logic [31:0]                    lo_r;
  logic [31:0]                    win_r [8];
  logic [3:0]                     nr;
  logic [3:0]                     nk;
  logic [aes_pkg::WORD_CNT_W-1:0] last_i;
  logic [31:0]                    w_prev, w_far, t, w_new, key32;
  logic                           done;

  assign nr     = aes_pkg::round_count(key_size);
  assign nk     = nr - 4'd6;
  assign last_i = {nr, 2'b11};
  assign done   = (i_r == last_i);

  // window holds the last eight words, w[i-1] at the top
  assign w_prev = win_r[7];
  assign w_far  = win_r[3'(4'd8 - nk)];
  assign key32  = i_r[0] ? key_word[i_r[2:1]][63:32] : key_word[i_r[2:1]][31:0];

  always_comb begin
    t        = w_prev;
    rcon_nxt = rcon_r;
    if (m_r == 3'd0) begin
      t        = aes_pkg::sub_word({w_prev[7:0], w_prev[31:8]}) ^ {24'd0, rcon_r};
      rcon_nxt = aes_pkg::xtime(rcon_r);
    end else if ((nk == 4'd8) && (m_r == 3'd4)) begin
      t = aes_pkg::sub_word(w_prev);
    end
  end

  always_comb begin
    if ({2'b00, i_r} < {2'b00, nk}) begin
      w_new = key32;
    end else begin
      w_new = w_far ^ t;
    end
  end

  always_comb begin
    unique case (state_r)
      aes_pkg::KX_IDLE: state_nxt = start ? aes_pkg::KX_RUN : aes_pkg::KX_IDLE;
      aes_pkg::KX_RUN:  state_nxt = done ? aes_pkg::KX_IDLE : aes_pkg::KX_RUN;
      default:          state_nxt = aes_pkg::KX_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b0;
    wr.en   = 1'b0;
    wr.idx  = i_r[aes_pkg::WORD_CNT_W-1:1];
    wr.data = {w_new, lo_r};
    i_nxt   = '0;
    m_nxt   = '0;
    unique case (state_r)
      aes_pkg::KX_IDLE: begin
        busy = 1'b0;
      end
      aes_pkg::KX_RUN: begin
        busy  = 1'b1;
        wr.en = i_r[0];
        i_nxt = i_r + 1'b1;
        m_nxt = ({1'b0, m_r} == nk - 4'd1) ? 3'd0 : m_r + 3'd1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aes_pkg::KX_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == aes_pkg::KX_RUN) begin
      i_r  <= i_nxt;
      m_r  <= m_nxt;
      lo_r <= w_new;
      if ({2'b00, i_r} >= {2'b00, nk}) begin
        rcon_r <= rcon_nxt;
      end
      for (int k = 0; k < 7; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[7] <= w_new;
    end else begin
      i_r    <= '0;
      m_r    <= '0;
      rcon_r <= 8'h01;
    end
  end

endmodule
`default_nettype wire

/* design/aes_block_encrypt_unit.sv */
// aes_block_encrypt_unit: 15-stage AES encryption pipeline with round key store
// depends on aes_pkg, aes_if.sv and aes_key_expand
// one request per cycle once the round keys are expanded, while the output is not stalled
// after reset and after a register write to index 0 to 4 the key schedule runs
// (one word per cycle in aes_key_expand) before the first request is taken
// a stage beyond the round count passes the state through; rst_n is synchronous
`default_nettype none
module aes_block_encrypt_unit #(
  parameter int unsigned ROUND_KEY_WORDS = 30
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [63:0]         cfg_data,
  aes_in_if.sink                   in_req,
  aes_out_if.source                out_rsp
);

  localparam int unsigned STAGES = aes_pkg::NUM_STAGES;

  logic [1:0]        key_size_r;
  logic [3:0][63:0]  key_word_r;
  logic              pending_r;
  logic [63:0]       rk_r [ROUND_KEY_WORDS];
  logic [3:0]        nr_r;

  logic [127:0]      st_r  [STAGES+1];
  logic              vld_r [STAGES+1];
  logic [127:0]      st_nxt [STAGES+1];
  logic [127:0]      rkey   [STAGES+1];

  aes_pkg::rk_wr_t   kx_wr;
  logic              kx_busy;
  logic              kx_start;
  logic              adv;
  logic              take;

  // a write to index 0 to 4 during a running schedule restarts it once that run ends
  assign kx_start = pending_r && !kx_busy;
  assign adv      = !vld_r[STAGES] || out_rsp.ready;
  assign take     = in_req.valid && in_req.ready;

  assign in_req.ready = adv && !pending_r && !kx_busy;

  aes_key_expand u_kx (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (kx_start),
    .key_size (key_size_r),
    .key_word (key_word_r),
    .wr       (kx_wr),
    .busy     (kx_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_size_r <= '0;
      key_word_r <= '0;
      pending_r  <= 1'b1;
    end else begin
      if (kx_start) begin
        pending_r <= 1'b0;
      end
      if (cfg_we && cfg_index <= aes_pkg::CFG_KEY_W3) begin
        pending_r <= 1'b1;
        if (cfg_index == aes_pkg::CFG_KEY_SIZE) begin
          key_size_r <= cfg_data[1:0];
        end else begin
          key_word_r[2'(cfg_index - aes_pkg::CFG_KEY_W0)] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    nr_r <= aes_pkg::round_count(key_size_r);
    if (kx_wr.en && kx_wr.idx < aes_pkg::KEY_IDX_W'(ROUND_KEY_WORDS)) begin
      rk_r[kx_wr.idx] <= kx_wr.data;
    end
  end

  // entries past the end of the store read as zero
  for (genvar r = 0; r <= STAGES; r++) begin : g_key
    if (2*r + 1 < ROUND_KEY_WORDS) begin : g_full
      assign rkey[r] = {rk_r[2*r+1], rk_r[2*r]};
    end else if (2*r < ROUND_KEY_WORDS) begin : g_half
      assign rkey[r] = {64'd0, rk_r[2*r]};
    end else begin : g_none
      assign rkey[r] = '0;
    end
  end

  assign st_nxt[0] = {in_req.plain_high, in_req.plain_low} ^ rkey[0];

  for (genvar r = 1; r <= STAGES; r++) begin : g_stage
    always_comb begin
      if (4'(r) < nr_r) begin
        st_nxt[r] = aes_pkg::enc_round(st_r[r-1], rkey[r], 1'b0);
      end else if (4'(r) == nr_r) begin
        st_nxt[r] = aes_pkg::enc_round(st_r[r-1], rkey[r], 1'b1);
      end else begin
        st_nxt[r] = st_r[r-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r <= STAGES; r++) begin
        vld_r[r] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= take;
      for (int r = 1; r <= STAGES; r++) begin
        vld_r[r] <= vld_r[r-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r <= STAGES; r++) begin
        st_r[r] <= st_nxt[r];
      end
    end
  end

  assign out_rsp.valid       = vld_r[STAGES];
  assign out_rsp.cipher_low  = st_r[STAGES][63:0];
  assign out_rsp.cipher_high = st_r[STAGES][127:64];

endmodule
`default_nettype wire

/* sim/testbench.sv */
// testbench: self-checking bench for aes_block_encrypt_unit with its own aes predictor
// depends on aes_pkg, aes_if.sv and the design files of aes_block_encrypt_unit
`default_nettype none
module testbench;

  localparam logic [1:0] KS_256 = 2'd2;
  localparam logic [1:0] KS_SAT = 2'd3;
  localparam logic [2:0] CFG_KEY_W1 = aes_pkg::CFG_KEY_W0 + 3'd1;
  localparam logic [2:0] CFG_KEY_W2 = aes_pkg::CFG_KEY_W0 + 3'd2;
  localparam int RAND_PHASES = 12;
  localparam int PHASE_BLOCKS = 106;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  typedef struct {
    logic       load_key;
    logic [1:0] ks;
    block_t     plain;
    logic       typed;
    block_t     cipher;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  aes_in_if  in_req ();
  aes_out_if out_rsp ();

  aes_block_encrypt_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_req   (in_req),
    .out_rsp  (out_rsp)
  );

  // predictor state
  logic [7:0]  sub_tab [256];
  logic [1:0]  key_size_m;
  logic [63:0] key_m [4];
  logic [63:0] round_keys [30];

  block_t cipher_q [$];
  int     mismatches = 0;
  int     blocks_sent = 0;
  int     blocks_seen = 0;
  int     cfg_writes = 0;
  bit     no_idle = 1'b0;
  bit     hold_out = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [7:0] gf_dbl(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_dbl(a);
    end
    return p;
  endfunction

  // inverse as x^254, then the affine map
  function automatic logic [7:0] sub_calc(input logic [7:0] x);
    logic [7:0] inv, sq;
    inv = 8'h01;
    sq = x;
    for (int e = 0; e < 8; e++) begin
      if (e != 0) inv = gf_prod(inv, sq);
      sq = gf_prod(sq, sq);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
           ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic int nrounds();
    return (key_size_m == aes_pkg::KS_128) ? 10 : (key_size_m == aes_pkg::KS_192) ? 12 : 14;
  endfunction

  function automatic logic [31:0] sub_w(input logic [31:0] w);
    return {sub_tab[w[31:24]], sub_tab[w[23:16]], sub_tab[w[15:8]], sub_tab[w[7:0]]};
  endfunction

  function automatic void schedule_keys();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    int nk, total;
    nk = nrounds() - 6;
    total = 4 * (nrounds() + 1);
    rc = 8'h01;
    for (int i = 0; i < 8; i++) w[i] = key_m[i / 2][32*(i % 2) +: 32];
    for (int i = nk; i < total; i++) begin
      t = w[i-1];
      if (i % nk == 0) begin
        t = sub_w({t[7:0], t[31:8]}) ^ {24'h0, rc};
        rc = gf_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_w(t);
      end
      w[i] = w[i-nk] ^ t;
    end
    for (int j = 0; j < total / 2; j++) round_keys[j] = {w[2*j+1], w[2*j]};
  endfunction

  function automatic block_t encrypt(input block_t pt);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    block_t ct;
    int nr;
    nr = nrounds();
    for (int i = 0; i < 8; i++) begin
      s[i] = pt.lo[8*i +: 8] ^ round_keys[0][8*i +: 8];
      s[i+8] = pt.hi[8*i +: 8] ^ round_keys[1][8*i +: 8];
    end
    for (int r = 1; r <= nr; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) t[w + 4*c] = sub_tab[s[w + 4*((c + w) % 4)]];
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        all = a0 ^ a1 ^ a2 ^ a3;
        if (r != nr) begin
          t[4*c]   = a0 ^ all ^ gf_dbl(a0 ^ a1);
          t[4*c+1] = a1 ^ all ^ gf_dbl(a1 ^ a2);
          t[4*c+2] = a2 ^ all ^ gf_dbl(a2 ^ a3);
          t[4*c+3] = a3 ^ all ^ gf_dbl(a3 ^ a0);
        end
      end
      for (int i = 0; i < 8; i++) begin
        s[i] = t[i] ^ round_keys[2*r][8*i +: 8];
        s[i+8] = t[i+8] ^ round_keys[2*r+1][8*i +: 8];
      end
    end
    for (int i = 0; i < 8; i++) begin
      ct.lo[8*i +: 8] = s[i];
      ct.hi[8*i +: 8] = s[i+8];
    end
    return ct;
  endfunction

  function automatic int idle_draw();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic logic [63:0] rand_word();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return 64'h0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_writes++;
    if (idx == aes_pkg::CFG_KEY_SIZE) key_size_m = data[1:0];
    else if (idx >= aes_pkg::CFG_KEY_W0 && idx <= aes_pkg::CFG_KEY_W3)
      key_m[idx - aes_pkg::CFG_KEY_W0] = data;
    schedule_keys();
  endtask

  task automatic wait_drained();
    in_req.valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_block(input block_t pt);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid <= 1'b1;
    in_req.plain_low <= pt.lo;
    in_req.plain_high <= pt.hi;
    do @(posedge clk); while (!in_req.ready);
    cipher_q.push_back(encrypt(pt));
    blocks_sent++;
  endtask

  // result side: random stalls, and one long hold-off on request
  initial begin
    int n;
    out_rsp.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      n = hold_out ? HOLD_CYCLES : idle_draw();
      hold_out = 1'b0;
      if (n > 0) begin
        out_rsp.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_rsp.ready <= 1'b1;
      do @(posedge clk); while (!out_rsp.valid);
    end
  end

  always @(posedge clk) begin
    block_t want;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      blocks_seen++;
      if (cipher_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h", out_rsp.cipher_high,
                                       out_rsp.cipher_low);
      end else begin
        want = cipher_q.pop_front();
        if (out_rsp.cipher_low !== want.lo || out_rsp.cipher_high !== want.hi) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cipher mismatch: expected %h %h got %h %h", want.hi, want.lo,
                     out_rsp.cipher_high, out_rsp.cipher_low);
        end
      end
    end
  end

  vec_t vecs [$];

  task automatic add_vec(input logic load, input logic [1:0] ks, input block_t pt,
                         input logic typed, input block_t ct);
    vec_t v;
    v.load_key = load; v.ks = ks; v.plain = pt; v.typed = typed; v.cipher = ct;
    vecs.push_back(v);
  endtask

  initial begin
    block_t fips_pt, got;
    logic [1:0] ks;
    for (int i = 0; i < 256; i++) sub_tab[i] = sub_calc(i[7:0]);
    in_req.valid <= 1'b0;
    in_req.plain_low <= '0;
    in_req.plain_high <= '0;
    key_size_m = aes_pkg::KS_128;
    for (int i = 0; i < 4; i++) key_m[i] = '0;
    schedule_keys();
    fips_pt = {64'hffeeddccbbaa9988, 64'h7766554433221100};

    // zero key straight after reset
    add_vec(1'b0, aes_pkg::KS_128, '0, 1'b1, {64'h2e2b34ca59fa4c88, 64'h3b2c8aefd44be966});
    add_vec(1'b0, aes_pkg::KS_128, '1, 1'b0, '0);
    add_vec(1'b1, aes_pkg::KS_128, fips_pt, 1'b1,
            {64'h5ac5b47080b7cdd8, 64'h30047b6ad8e0c469});
    add_vec(1'b0, aes_pkg::KS_128, '0, 1'b0, '0);
    add_vec(1'b0, aes_pkg::KS_128, '1, 1'b0, '0);
    add_vec(1'b0, aes_pkg::KS_128, {64'h5555555555555555, 64'haaaaaaaaaaaaaaaa}, 1'b0, '0);
    add_vec(1'b1, aes_pkg::KS_192, fips_pt, 1'b1,
            {64'h91710deca070af6e, 64'he0df4c86a47ca9dd});
    add_vec(1'b0, aes_pkg::KS_192, '0, 1'b0, '0);
    add_vec(1'b0, aes_pkg::KS_192, '1, 1'b0, '0);
    add_vec(1'b1, KS_256, fips_pt, 1'b1, {64'h8960494b9049fcea, 64'hbf456751cab7a28e});
    add_vec(1'b0, KS_256, '0, 1'b0, '0);
    add_vec(1'b0, KS_256, '1, 1'b0, '0);
    // key size three saturates to 256
    add_vec(1'b1, KS_SAT, fips_pt, 1'b1, {64'h8960494b9049fcea, 64'hbf456751cab7a28e});
    add_vec(1'b0, KS_SAT, {64'haaaaaaaaaaaaaaaa, 64'h5555555555555555}, 1'b0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vecs[i]) begin
      if (vecs[i].load_key) begin
        wait_drained();
        cfg_write(aes_pkg::CFG_KEY_W0, 64'h0706050403020100);
        cfg_write(CFG_KEY_W1, 64'h0f0e0d0c0b0a0908);
        cfg_write(CFG_KEY_W2, 64'h1716151413121110);
        cfg_write(aes_pkg::CFG_KEY_W3, 64'h1f1e1d1c1b1a1918);
        // out-of-range indexes must leave the key alone
        cfg_write(aes_pkg::CFG_KEY_W3 + 3'd1, '1);
        cfg_write(aes_pkg::CFG_KEY_W3 + 3'd3, 64'h0123456789abcdef);
        cfg_write(aes_pkg::CFG_KEY_SIZE, {62'h0, vecs[i].ks});
        cfg_we <= 1'b0;
      end
      if (vecs[i].typed) begin
        got = encrypt(vecs[i].plain);
        if (got !== vecs[i].cipher) begin
          mismatches++;
          if (mismatches <= 10) $display("predictor disagrees with known vector %0d", i);
        end
      end
      send_block(vecs[i].plain);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained();
      ks = (p < 4) ? p[1:0] : 2'($urandom_range(0, 3));
      for (int w = 0; w < 4; w++)
        if (p < 2 || $urandom_range(0, 2) != 0)
          cfg_write(aes_pkg::CFG_KEY_W0 + 3'(w), rand_word());
      if ($urandom_range(0, 3) == 0) cfg_write(3'($urandom_range(5, 7)), rand_word());
      cfg_write(aes_pkg::CFG_KEY_SIZE, {62'h0, ks});
      cfg_we <= 1'b0;
      no_idle = (p % 4 == 1);
      if (p == 2) hold_out = 1'b1;
      for (int k = 0; k < PHASE_BLOCKS; k++) send_block({rand_word(), rand_word()});
    end
    in_req.valid <= 1'b0;
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (cipher_q.size() != 0) mismatches++;

    $display("covered %0d blocks, %0d results, %0d register writes,", blocks_sent,
             blocks_seen, cfg_writes);
    $display("all key sizes incl. saturated size, stalls and a long output hold-off");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
